FILE: hw/rtl/itsu_pkg.sv
// Shared types and constants for the incubator thermostat setpoint editor.
package itsu_pkg;

    // Field widths
    localparam int TEMP_W     = 12;
    localparam int HUM_W      = 10;
    localparam int OFFSET_W   = 8;
    localparam int TICKS_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Setpoint limits and reset values, tenths of a degree or percent
    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -12'sd400;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 12'sd1250;
    localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd375;
    localparam logic [HUM_W-1:0]         HUM_MAX    = 10'd1000;
    localparam logic [HUM_W-1:0]         HUM_RESET  = 10'd500;

    // Register reset values
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET  = 8'sd10;
    localparam logic [TICKS_W-1:0]         HOLD_RESET    = 10'd500;
    localparam logic [TICKS_W-1:0]         TIMEOUT_RESET = 10'd400;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDIT_TIMEOUT = 2'd2;

    // UI mode, also the code of the leading button
    typedef enum logic [1:0] {
        MODE_RUN  = 2'd0,
        MODE_TEMP = 2'd1,
        MODE_HUM  = 2'd2
    } mode_t;

    // One result beat
    typedef struct packed {
        logic                     lamp_level;
        logic                     fan_level;
        logic [1:0]               ui_mode;
        logic signed [TEMP_W-1:0] temp_target;
        logic [HUM_W-1:0]         hum_target;
        logic                     saved;
    } result_t;

endpackage

FILE: hw/rtl/incubator_thermostat_setpoint_ui_unit.sv
// Top level: on/off lamp and fan regulator with a two-button setpoint editor.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one 10 ms tick per beat: button
//   levels, a sample-valid flag and the temperature and humidity readings.
//   Result channel (m_valid/m_ready) returns exactly one beat per tick: relay
//   levels, UI mode, both setpoints and the saved pulse.
//   Configuration channel (cfg_valid/cfg_ready) writes temp_offset (index 0),
//   hold_ticks (index 1) and edit_timeout (index 2); other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
// Timing:
//   One tick is accepted per cycle while s_ready is high. The whole tick
//   update is a single pass of counter, compare and small adds from the
//   state registers into the result register, or the skid on a stall.
// Reset:
//   aresetn low returns to run mode with setpoints 37.5 C and 50.0 %RH,
//   relays low, counters cleared and registers at their defaults.
// Stall:
//   A two-entry output stage (result register plus skid) lets one more tick
//   in while m_ready is low; s_ready then drops until the receiver drains.
module incubator_thermostat_setpoint_ui_unit #(
    parameter int COUNT_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Tick input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_up_pressed,
    input  logic                                 s_down_pressed,
    input  logic                                 s_sample_valid,
    input  logic signed [itsu_pkg::TEMP_W-1:0]   s_temp_sample,
    input  logic [itsu_pkg::HUM_W-1:0]           s_hum_sample,
    // Result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_lamp_level,
    output logic                                 m_fan_level,
    output logic [1:0]                           m_ui_mode,
    output logic signed [itsu_pkg::TEMP_W-1:0]   m_temp_target,
    output logic [itsu_pkg::HUM_W-1:0]           m_hum_target,
    output logic                                 m_saved,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [itsu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [itsu_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import itsu_pkg::*;

    localparam int CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers
    logic signed [OFFSET_W-1:0] temp_offset_reg;
    logic [TICKS_W-1:0]         hold_ticks_reg;
    logic [TICKS_W-1:0]         edit_timeout_reg;

    // Tick state
    mode_t                      mode_reg, mode_next;
    logic [COUNT_BITS-1:0]      hold_count_reg, hold_count_next;
    logic [COUNT_BITS-1:0]      idle_count_reg, idle_count_next;
    logic                       await_release_reg, await_release_next;
    logic                       up_prev_reg, down_prev_reg;
    logic signed [TEMP_W-1:0]   temp_set_reg, temp_set_next;
    logic [HUM_W-1:0]           hum_set_reg, hum_set_next;
    logic                       lamp_reg, lamp_next;
    logic                       fan_reg, fan_next;
    logic                       saved_next;

    // Output stage
    result_t                    out_reg, skid_reg, result_next;
    logic                       out_valid_reg, skid_valid_reg;

    logic                       accept;
    mode_t                      lead, prev_lead;
    logic                       entry_btn, dn_rel, up_rel, busy;
    logic signed [1:0]          step;
    logic [COUNT_BITS-1:0]      hold_inc, idle_inc;
    logic signed [TEMP_W:0]     temp_sum, temp_corr;
    logic signed [HUM_W:0]      hum_sum;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes, masked to register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_offset_reg  <= OFFSET_RESET;
            hold_ticks_reg   <= HOLD_RESET;
            edit_timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TEMP_OFFSET:  temp_offset_reg  <= signed'(cfg_data[OFFSET_W-1:0]);
                REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data[TICKS_W-1:0];
                REG_EDIT_TIMEOUT: edit_timeout_reg <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Leading button now and on the previous tick
    always_comb begin
        lead      = s_up_pressed ? MODE_TEMP : (s_down_pressed ? MODE_HUM : MODE_RUN);
        prev_lead = up_prev_reg ? MODE_TEMP : (down_prev_reg ? MODE_HUM : MODE_RUN);
        hold_inc  = (hold_count_reg < COUNT_MAX) ? hold_count_reg + 1'b1 : hold_count_reg;
        idle_inc  = (idle_count_reg < COUNT_MAX) ? idle_count_reg + 1'b1 : idle_count_reg;
        dn_rel    = down_prev_reg && !s_down_pressed;
        up_rel    = up_prev_reg && !s_up_pressed;
        entry_btn = (mode_reg == MODE_TEMP) ? s_up_pressed : s_down_pressed;
        busy      = s_up_pressed || s_down_pressed || dn_rel || up_rel;
        // net step: up release +1, down release -1, both together cancel
        case ({up_rel, dn_rel})
            2'b10:   step = 2'sd1;
            2'b01:   step = -2'sd1;
            default: step = 2'sd0;
        endcase
        temp_sum  = (TEMP_W+1)'(temp_set_reg) + (TEMP_W+1)'(step);
        hum_sum   = signed'({1'b0, hum_set_reg}) + (HUM_W+1)'(step);
        temp_corr = (TEMP_W+1)'(s_temp_sample) + (TEMP_W+1)'(temp_offset_reg);
    end

    // Tick update
    always_comb begin
        mode_next          = mode_reg;
        hold_count_next    = hold_count_reg;
        idle_count_next    = idle_count_reg;
        await_release_next = await_release_reg;
        temp_set_next      = temp_set_reg;
        hum_set_next       = hum_set_reg;
        lamp_next          = lamp_reg;
        fan_next           = fan_reg;
        saved_next         = 1'b0;

        if (mode_reg == MODE_RUN) begin
            // hold counting toward edit entry
            if (lead == MODE_RUN) begin
                hold_count_next = '0;
            end else if (lead != prev_lead) begin
                hold_count_next = COUNT_BITS'(1);
            end else begin
                hold_count_next = hold_inc;
            end
            if (lead != MODE_RUN &&
                CMP_W'(hold_count_next) >= CMP_W'(hold_ticks_reg)) begin
                mode_next          = lead;
                await_release_next = 1'b1;
                hold_count_next    = '0;
                idle_count_next    = '0;
            end
        end else if (await_release_reg) begin
            // ignore everything until the entry button is let go
            if (!entry_btn) begin
                await_release_next = 1'b0;
            end
            idle_count_next = '0;
        end else begin
            // nudge the setpoint being edited, saturating at its setpoint limits
            if (mode_reg == MODE_TEMP) begin
                if (temp_sum < (TEMP_W+1)'(TEMP_MIN)) begin
                    temp_set_next = TEMP_MIN;
                end else if (temp_sum > (TEMP_W+1)'(TEMP_MAX)) begin
                    temp_set_next = TEMP_MAX;
                end else begin
                    temp_set_next = temp_sum[TEMP_W-1:0];
                end
            end else begin
                if (hum_sum < 0) begin
                    hum_set_next = '0;
                end else if (hum_sum > signed'({1'b0, HUM_MAX})) begin
                    hum_set_next = HUM_MAX;
                end else begin
                    hum_set_next = hum_sum[HUM_W-1:0];
                end
            end
            // idle timeout ends editing
            if (busy) begin
                idle_count_next = '0;
            end else begin
                idle_count_next = idle_inc;
                if (CMP_W'(idle_inc) >= CMP_W'(edit_timeout_reg)) begin
                    mode_next       = MODE_RUN;
                    saved_next      = 1'b1;
                    idle_count_next = '0;
                    hold_count_next = '0;
                end
            end
        end

        // relays follow samples only on ticks that start in run mode
        if (mode_reg == MODE_RUN && s_sample_valid) begin
            lamp_next = (temp_corr > (TEMP_W+1)'(temp_set_reg));
            fan_next  = !(s_hum_sample > hum_set_reg);
        end

        result_next.lamp_level  = lamp_next;
        result_next.fan_level   = fan_next;
        result_next.ui_mode     = mode_next;
        result_next.temp_target = temp_set_next;
        result_next.hum_target  = hum_set_next;
        result_next.saved       = saved_next;
    end

    // State registers, advance once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_RUN;
            hold_count_reg    <= '0;
            idle_count_reg    <= '0;
            await_release_reg <= 1'b0;
            up_prev_reg       <= 1'b0;
            down_prev_reg     <= 1'b0;
            temp_set_reg      <= TEMP_RESET;
            hum_set_reg       <= HUM_RESET;
            lamp_reg          <= 1'b0;
            fan_reg           <= 1'b0;
        end else if (accept) begin
            mode_reg          <= mode_next;
            hold_count_reg    <= hold_count_next;
            idle_count_reg    <= idle_count_next;
            await_release_reg <= await_release_next;
            up_prev_reg       <= s_up_pressed;
            down_prev_reg     <= s_down_pressed;
            temp_set_reg      <= temp_set_next;
            hum_set_reg       <= hum_set_next;
            lamp_reg          <= lamp_next;
            fan_reg           <= fan_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result_next;
            end
        end else if (accept) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_lamp_level  = out_reg.lamp_level;
    assign m_fan_level   = out_reg.fan_level;
    assign m_ui_mode     = out_reg.ui_mode;
    assign m_temp_target = out_reg.temp_target;
    assign m_hum_target  = out_reg.hum_target;
    assign m_saved       = out_reg.saved;

    // Checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending result");

    a_await_in_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        await_release_reg |-> (mode_reg != MODE_RUN))
        else $error("release wait outside edit mode");

    a_saved_from_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && saved_next) |-> (mode_reg != MODE_RUN && mode_next == MODE_RUN))
        else $error("saved pulse without leaving edit mode");

    a_entry_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_RUN && mode_next != MODE_RUN) |=> await_release_reg)
        else $error("edit entry did not arm the release wait");

endmodule

FILE: dv/incubator_thermostat_setpoint_ui_unit_tb.sv
// Self-checking testbench for the incubator thermostat setpoint editor.

// Tracks the regulator and the results it must produce, one per tick beat
class tick_result_book;
    int count_max;
    // register copies
    int offset;
    int hold_limit;
    int idle_limit;
    // regulator state
    itsu_pkg::mode_t mode;
    int hold_count;
    int idle_count;
    bit await_rel;
    bit up_prev;
    bit dn_prev;
    int temp_set;
    int hum_set;
    bit lamp;
    bit fan;
    // results still owed by the block
    itsu_pkg::result_t awaited[$];
    int mismatches;

    function new(int count_bits);
        count_max  = (1 << count_bits) - 1;
        offset     = int'(itsu_pkg::OFFSET_RESET);
        hold_limit = int'(itsu_pkg::HOLD_RESET);
        idle_limit = int'(itsu_pkg::TIMEOUT_RESET);
        mode       = itsu_pkg::MODE_RUN;
        hold_count = 0;
        idle_count = 0;
        await_rel  = 1'b0;
        up_prev    = 1'b0;
        dn_prev    = 1'b0;
        temp_set   = int'(itsu_pkg::TEMP_RESET);
        hum_set    = int'(itsu_pkg::HUM_RESET);
        lamp       = 1'b0;
        fan        = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [itsu_pkg::CFG_IDX_W-1:0] idx,
                            logic [itsu_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            itsu_pkg::REG_TEMP_OFFSET:  offset = int'($signed(data[7:0]));
            itsu_pkg::REG_HOLD_TICKS:   hold_limit = int'(data);
            itsu_pkg::REG_EDIT_TIMEOUT: idle_limit = int'(data);
            default: ;
        endcase
    endfunction

    function int limit(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the regulator by one accepted tick and queue its result
    function void note_tick(bit up, bit dn, bit sv,
                            logic signed [itsu_pkg::TEMP_W-1:0] tmp,
                            logic [itsu_pkg::HUM_W-1:0] hum);
        itsu_pkg::result_t r;
        itsu_pkg::mode_t start_mode;
        itsu_pkg::mode_t lead;
        itsu_pkg::mode_t prev_lead;
        int step;
        bit saved_pulse;
        bit entry;
        bit dn_rel;
        bit up_rel;

        start_mode  = mode;
        saved_pulse = 1'b0;
        if (mode == itsu_pkg::MODE_RUN) begin
            // hold counting on the leading button, up wins
            lead = up ? itsu_pkg::MODE_TEMP : (dn ? itsu_pkg::MODE_HUM : itsu_pkg::MODE_RUN);
            prev_lead = up_prev ? itsu_pkg::MODE_TEMP :
                        (dn_prev ? itsu_pkg::MODE_HUM : itsu_pkg::MODE_RUN);
            if (lead == itsu_pkg::MODE_RUN) hold_count = 0;
            else if (lead != prev_lead) hold_count = 1;
            else if (hold_count < count_max) hold_count++;
            if (lead != itsu_pkg::MODE_RUN && hold_count >= hold_limit) begin
                mode       = lead;
                await_rel  = 1'b1;
                hold_count = 0;
                idle_count = 0;
            end
        end else if (await_rel) begin
            // nothing happens until the entry button is let go
            entry = (mode == itsu_pkg::MODE_TEMP) ? up : dn;
            if (!entry) await_rel = 1'b0;
            idle_count = 0;
        end else begin
            dn_rel = dn_prev && !dn;
            up_rel = up_prev && !up;
            step   = int'(up_rel) - int'(dn_rel);
            if (mode == itsu_pkg::MODE_TEMP) begin
                temp_set = limit(temp_set + step, int'(itsu_pkg::TEMP_MIN),
                                 int'(itsu_pkg::TEMP_MAX));
            end else begin
                hum_set = limit(hum_set + step, 0, int'(itsu_pkg::HUM_MAX));
            end
            if (up || dn || dn_rel || up_rel) begin
                idle_count = 0;
            end else begin
                if (idle_count < count_max) idle_count++;
                if (idle_count >= idle_limit) begin
                    mode        = itsu_pkg::MODE_RUN;
                    saved_pulse = 1'b1;
                    idle_count  = 0;
                    hold_count  = 0;
                end
            end
        end

        // relays follow samples only on ticks that start in run mode
        if (start_mode == itsu_pkg::MODE_RUN && sv) begin
            lamp = (int'(tmp) + offset > temp_set);
            fan  = !(int'(hum) > hum_set);
        end
        up_prev = up;
        dn_prev = dn;

        r.lamp_level  = lamp;
        r.fan_level   = fan;
        r.ui_mode     = mode;
        r.temp_target = temp_set[itsu_pkg::TEMP_W-1:0];
        r.hum_target  = hum_set[itsu_pkg::HUM_W-1:0];
        r.saved       = saved_pulse;
        awaited.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed result
    function void check_result(itsu_pkg::result_t got);
        itsu_pkg::result_t want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: lamp %0b fan %0b mode %0d temp %0d hum %0d saved %0b",
                         got.lamp_level, got.fan_level, got.ui_mode, got.temp_target,
                         got.hum_target, got.saved);
            return;
        end
        want = awaited.pop_front();
        if (got.lamp_level !== want.lamp_level || got.fan_level !== want.fan_level ||
            got.ui_mode !== want.ui_mode || got.temp_target !== want.temp_target ||
            got.hum_target !== want.hum_target || got.saved !== want.saved) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result mismatch (exp/got): lamp %0b/%0b fan %0b/%0b mode %0d/%0d",
                         want.lamp_level, got.lamp_level, want.fan_level, got.fan_level,
                         want.ui_mode, got.ui_mode);
                $display("  temp %0d/%0d hum %0d/%0d saved %0b/%0b",
                         want.temp_target, got.temp_target, want.hum_target, got.hum_target,
                         want.saved, got.saved);
            end
        end
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction

    function bit failed();
        return (mismatches != 0) || (awaited.size() != 0);
    endfunction
endclass

module incubator_thermostat_setpoint_ui_unit_tb;
    import itsu_pkg::*;

    localparam int COUNT_BITS   = 10;
    localparam int RANDOM_TICKS = 400;
    localparam int CYCLE_LIMIT  = 50000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic                     s_up_pressed   = 1'b0;
    logic                     s_down_pressed = 1'b0;
    logic                     s_sample_valid = 1'b0;
    logic signed [TEMP_W-1:0] s_temp_sample  = '0;
    logic [HUM_W-1:0]         s_hum_sample   = '0;

    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_lamp_level;
    logic                     m_fan_level;
    logic [1:0]               m_ui_mode;
    logic signed [TEMP_W-1:0] m_temp_target;
    logic [HUM_W-1:0]         m_hum_target;
    logic                     m_saved;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tick_result_book book;
    int          burst_left = 0;
    int          ticks_sent = 0;
    int          cur_hold   = int'(HOLD_RESET);
    int          cur_tmo    = int'(TIMEOUT_RESET);
    int unsigned cycle_count = 0;

    incubator_thermostat_setpoint_ui_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_up_pressed   (s_up_pressed),
        .s_down_pressed (s_down_pressed),
        .s_sample_valid (s_sample_valid),
        .s_temp_sample  (s_temp_sample),
        .s_hum_sample   (s_hum_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lamp_level   (m_lamp_level),
        .m_fan_level    (m_fan_level),
        .m_ui_mode      (m_ui_mode),
        .m_temp_target  (m_temp_target),
        .m_hum_target   (m_hum_target),
        .m_saved        (m_saved),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each beat, stall in styles that change over time
    int stall_style = 0;
    int stall_left  = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                book.check_result('{m_lamp_level, m_fan_level, m_ui_mode, m_temp_target,
                                    m_hum_target, m_saved});
            end
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_style)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= (cycle_count[1:0] == 2'd0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Sample values: half near the current switch points, half anywhere in range
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int v;
        if ($urandom_range(0, 1) == 1)
            v = book.temp_set - book.offset + int'($urandom_range(0, 40)) - 20;
        else
            v = int'($urandom_range(0, 1650)) - 400;
        if (v < TEMP_MIN) v = TEMP_MIN;
        if (v > TEMP_MAX) v = TEMP_MAX;
        return v[TEMP_W-1:0];
    endfunction

    function automatic logic [HUM_W-1:0] pick_hum();
        int v;
        if ($urandom_range(0, 1) == 1)
            v = book.hum_set + int'($urandom_range(0, 40)) - 20;
        else
            v = int'($urandom_range(0, 1000));
        if (v < 0) v = 0;
        if (v > HUM_MAX) v = HUM_MAX;
        return v[HUM_W-1:0];
    endfunction

    // One tick beat, sent in bursts with random gaps between them
    task automatic send_tick(input bit up, input bit dn, input bit sv,
                             input logic signed [TEMP_W-1:0] t, input logic [HUM_W-1:0] h);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        s_valid        <= 1'b1;
        s_up_pressed   <= up;
        s_down_pressed <= dn;
        s_sample_valid <= sv;
        s_temp_sample  <= t;
        s_hum_sample   <= h;
        do @(posedge aclk); while (!s_ready);
        book.note_tick(up, dn, sv, t, h);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic tick(input bit up, input bit dn);
        send_tick(up, dn, bit'($urandom_range(0, 1)), pick_temp(), pick_hum());
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        book.write_reg(idx, d);
    endtask

    // Write all registers while the block is idle
    task automatic program_regs(input int off, input int hold, input int tmo,
                                input bit touch_unused);
        logic [CFG_DATA_W-1:0] d;
        drain();
        d      = off[CFG_DATA_W-1:0];
        d[9:8] = 2'($urandom_range(0, 3));  // upper bits are dropped by the block
        put_reg(REG_TEMP_OFFSET, d);
        put_reg(REG_HOLD_TICKS, hold[CFG_DATA_W-1:0]);
        put_reg(REG_EDIT_TIMEOUT, tmo[CFG_DATA_W-1:0]);
        if (touch_unused) put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_hold = hold;
        cur_tmo  = tmo;
    endtask

    // Hold the entry button(s) long enough, then let go
    task automatic enter_edit(input bit up, input bit dn);
        repeat (((cur_hold == 0) ? 1 : cur_hold) + $urandom_range(0, 2)) tick(up, dn);
        repeat ($urandom_range(1, 2)) tick(1'b0, 1'b0);
    endtask

    task automatic pulse(input bit up, input bit dn, input int len);
        repeat (len) tick(up, dn);
        tick(1'b0, 1'b0);
    endtask

    // Step one setpoint one way and then the other, then let the edit time out
    task automatic sweep(input bit temp_edit, input int first_n, input bit first_up,
                         input int second_n);
        enter_edit(temp_edit, !temp_edit);
        repeat (first_n) pulse(first_up, !first_up, 1);
        repeat (second_n) pulse(!first_up, first_up, 1);
        repeat (cur_tmo + 1) tick(1'b0, 1'b0);
    endtask

    // Well-formed edit: entry, a few presses, then the timeout
    task automatic edit_session();
        int which;
        int kind;
        int len;
        which = $urandom_range(0, 4);
        enter_edit(which < 2 || which == 4, which >= 2);
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(1, 3);
            case (kind)
                0: pulse(1'b1, 1'b0, len);
                1: pulse(1'b0, 1'b1, len);
                2: pulse(1'b1, 1'b1, len);
                default: begin
                    // staggered release of both buttons
                    repeat (len) tick(1'b1, 1'b1);
                    tick(1'b0, 1'b1);
                    tick(1'b0, 1'b0);
                end
            endcase
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(0, cur_tmo)) tick(1'b0, 1'b0);
        end
        repeat (cur_tmo + $urandom_range(0, 2)) tick(1'b0, 1'b0);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 10)) tick(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
    endtask

    initial begin
        int start;
        int chunk_end;
        int phase;
        int off;

        book = new(COUNT_BITS);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: sample extremes and the lamp and fan switch points
        send_tick(1'b0, 1'b0, 1'b1, TEMP_MIN, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, TEMP_MAX, HUM_MAX);
        send_tick(1'b0, 1'b0, 1'b1, 12'sd365, 10'd500);
        send_tick(1'b0, 1'b0, 1'b1, 12'sd366, 10'd501);
        send_tick(1'b0, 1'b0, 1'b0, TEMP_MIN, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, -12'sd1, 10'd1);
        send_tick(1'b0, 1'b0, 1'b1, 12'sd1024, 10'd512);

        // Reset hold: short holds of either button stay in run mode
        repeat (12) tick(1'b0, 1'b1);
        repeat (12) tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);

        // Zero hold and zero timeout, lowest offset
        program_regs(-100, 0, 0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1, TEMP_MIN, HUM_MAX);  // enters at once, relays update
        send_tick(1'b0, 1'b1, 1'b1, TEMP_MAX, 10'd0);    // waiting for release, ignored
        send_tick(1'b0, 1'b0, 1'b1, TEMP_MAX, 10'd0);    // release clears the wait
        send_tick(1'b0, 1'b0, 1'b1, TEMP_MAX, 10'd0);    // first idle tick saves
        send_tick(1'b1, 1'b1, 1'b1, 12'sd500, 10'd300);  // both held, up leads
        send_tick(1'b0, 1'b1, 1'b0, 12'sd0, 10'd0);
        send_tick(1'b1, 1'b1, 1'b0, 12'sd0, 10'd0);
        send_tick(1'b0, 1'b0, 1'b0, 12'sd0, 10'd0);      // both let go together
        send_tick(1'b1, 1'b0, 1'b0, 12'sd0, 10'd0);
        send_tick(1'b0, 1'b0, 1'b0, 12'sd0, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, 12'sd200, 10'd900);

        // Setpoints stepped down and up, highest offset
        program_regs(100, 2, 3, 1'b0);
        sweep(1'b1, 20, 1'b0, 30);
        sweep(1'b0, 15, 1'b1, 25);

        // Largest hold and timeout: a short hold stays in run mode
        program_regs(7, 1023, 1023, 1'b0);
        repeat (12) tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);

        // Random part: mostly edit sessions, some button noise
        start = ticks_sent;
        phase = 0;
        while (ticks_sent - start < RANDOM_TICKS) begin
            if (phase == 0) off = -100;
            else if (phase == 1) off = 100;
            else off = int'($urandom_range(0, 200)) - 100;
            program_regs(off, $urandom_range(1, 6), $urandom_range(1, 8), 1'b1);
            chunk_end = ticks_sent + 80;
            while (ticks_sent < chunk_end) begin
                if ($urandom_range(0, 3) != 0) edit_session();
                else noise_burst();
            end
            phase++;
        end

        drain();
        repeat (4) @(posedge aclk);
        if (!book.failed()) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
